// File: design/rational_fraction_alu_macros.svh
// Assertion helpers for the checking module rfa_back
`ifndef RATIONAL_FRACTION_ALU_MACROS_SVH
`define RATIONAL_FRACTION_ALU_MACROS_SVH

// property must hold at every edge out of reset
`define RFA_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen
`define RFA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// File: design/rfa_pkg.sv
package rfa_pkg;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_SQR = 4'd4;
	localparam logic [3:0] OP_RCP = 4'd5;
	localparam logic [3:0] OP_NEG = 4'd6;
	localparam logic [3:0] OP_EQ  = 4'd7;
	localparam logic [3:0] OP_GT  = 4'd8;
	localparam logic [3:0] OP_LT  = 4'd9;

	// classified item handed from front to back
	typedef struct packed {
		logic               red;
		logic signed [63:0] num;
		logic signed [63:0] den;
		logic               flag;
		logic               status;
	} q_entry_t;

endpackage

// File: design/rfa_front.sv
module rfa_front #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [3:0]         req_type,
	input  logic signed [31:0] a_num,
	input  logic [30:0]        a_den,
	input  logic signed [31:0] b_num,
	input  logic [30:0]        b_den,
	output logic               q_push,
	input  logic               q_full,
	output rfa_pkg::q_entry_t  q_wdata
);

	localparam int SH = 32 - OPERAND_WIDTH;
	localparam logic [30:0] DEN_MASK = 31'((64'd1 << (OPERAND_WIDTH - 1)) - 64'd1);

	logic signed [31:0] an_sh, bn_sh, an, bn;
	logic [30:0]        ad, bd;
	logic signed [32:0] m1a, m1b, m2a, m2b, m3a, m3b;
	logic signed [65:0] p1w, p2w, p3w;
	logic               adv;

	logic               v_s1;
	logic [3:0]         op_s1;
	logic signed [63:0] p1_s1, p2_s1, p3_s1;
	logic signed [31:0] an_s1;
	logic [30:0]        ad_s1;
	logic               eq_s1, az_s1, bz_s1, dnz_s1;

	assign an_sh = a_num <<< SH;
	assign bn_sh = b_num <<< SH;
	assign an    = an_sh >>> SH;
	assign bn    = bn_sh >>> SH;
	assign ad    = a_den & DEN_MASK;
	assign bd    = b_den & DEN_MASK;

	// three shared multipliers, operands steered by the opcode
	always_comb begin
		m1a = 33'(an);
		m1b = (req_type == rfa_pkg::OP_MUL) ? 33'(bn) :
		      (req_type == rfa_pkg::OP_SQR) ? 33'(an) : $signed({2'b00, bd});
		m2a = $signed({2'b00, ad});
		m2b = 33'(bn);
		m3a = $signed({2'b00, ad});
		m3b = (req_type == rfa_pkg::OP_DIV) ? 33'(bn) :
		      (req_type == rfa_pkg::OP_SQR) ? $signed({2'b00, ad}) : $signed({2'b00, bd});
	end

	assign p1w = m1a * m1b;
	assign p2w = m2a * m2b;
	assign p3w = m3a * m3b;

	assign full = v_s1 && q_full;
	assign adv  = !v_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push) begin
			op_s1  <= req_type;
			p1_s1  <= p1w[63:0];
			p2_s1  <= p2w[63:0];
			p3_s1  <= p3w[63:0];
			an_s1  <= an;
			ad_s1  <= ad;
			eq_s1  <= (an == bn) && (ad == bd);
			az_s1  <= (an == 32'sd0);
			bz_s1  <= (bn == 32'sd0);
			dnz_s1 <= (ad != '0) && (bd != '0);
		end
	end

	assign q_push = v_s1 && !q_full;

	always_comb begin
		q_wdata        = '0;
		q_wdata.den    = 64'sd1;
		case (op_s1)
			rfa_pkg::OP_ADD: begin
				q_wdata.red = 1'b1;
				q_wdata.num = p1_s1 + p2_s1;
				q_wdata.den = p3_s1;
			end
			rfa_pkg::OP_SUB: begin
				q_wdata.red = 1'b1;
				q_wdata.num = p1_s1 - p2_s1;
				q_wdata.den = p3_s1;
			end
			rfa_pkg::OP_MUL, rfa_pkg::OP_SQR: begin
				q_wdata.red = 1'b1;
				q_wdata.num = p1_s1;
				q_wdata.den = p3_s1;
			end
			rfa_pkg::OP_DIV: begin
				if (bz_s1) begin
					q_wdata.status = 1'b1;
				end else begin
					q_wdata.red = 1'b1;
					q_wdata.num = p1_s1;
					q_wdata.den = p3_s1;
				end
			end
			rfa_pkg::OP_RCP: begin
				if (az_s1) begin
					q_wdata.status = 1'b1;
				end else begin
					q_wdata.red = 1'b1;
					q_wdata.num = $signed({33'd0, ad_s1});
					q_wdata.den = 64'(an_s1);
				end
			end
			rfa_pkg::OP_NEG: begin
				q_wdata.red = 1'b1;
				q_wdata.num = -64'(an_s1);
				q_wdata.den = $signed({33'd0, ad_s1});
			end
			rfa_pkg::OP_EQ: q_wdata.flag = eq_s1;
			rfa_pkg::OP_GT: q_wdata.flag = dnz_s1 && (p1_s1 > p2_s1);
			rfa_pkg::OP_LT: q_wdata.flag = dnz_s1 && (p1_s1 < p2_s1);
			default: ;
		endcase
	end

endmodule

// File: design/rfa_queue.sv
module rfa_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  rfa_pkg::q_entry_t wdata,
	output logic              q_full,
	input  logic              rd,
	output logic              q_valid,
	output rfa_pkg::q_entry_t rdata
);

	rfa_pkg::q_entry_t slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign rdata   = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) slot_q[wp_q] <= wdata;
	end

endmodule

// File: design/rfa_back.sv
`include "rational_fraction_alu_macros.svh"

module rfa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  rfa_pkg::q_entry_t   rdata,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output logic signed [63:0]  res_num,
	output logic [62:0]         res_den,
	output logic                cmp_flag,
	output logic                status
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_GCD  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [63:0] x_q, y_q, g_q;
	logic [6:0]  k_q;
	logic        neg_q;
	logic [64:0] rn_q, rd_q;
	logic [63:0] qn_q, qd_q;
	logic [5:0]  cnt_q;
	logic signed [63:0] pn_q;
	logic [62:0] pd_q;
	logic        pf_q, ps_q;
	logic [63:0] dn_q, dd_q;

	logic               res_valid_q;
	logic signed [63:0] res_num_q;
	logic [62:0]        res_den_q;
	logic               res_flag_q, res_status_q;

	logic signed [63:0] nf, df;
	logic [63:0]        nabs;
	logic [64:0]        tn, td;
	logic               out_free;

	assign df   = rdata.den[63] ? -rdata.den : rdata.den;
	assign nf   = rdata.den[63] ? -rdata.num : rdata.num;
	assign nabs = nf[63] ? 64'(-nf) : 64'(nf);

	assign tn = {rn_q[63:0], qn_q[63]};
	assign td = {rd_q[63:0], qd_q[63]};

	assign out_free = !res_valid_q || pop;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= ((state_q == ST_DONE) && out_free) || (res_valid_q && !pop);
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (rdata.red && rdata.num != 0 && rdata.den != 0) state_q <= ST_GCD;
						else state_q <= ST_DONE;
					end
				end
				ST_GCD: begin
					if (x_q == '0 || y_q == '0) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == 6'd63) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q   <= nabs;
				y_q   <= 64'(df);
				k_q   <= '0;
				neg_q <= nf[63];
				pn_q  <= '0;
				pd_q  <= 63'd1;
				pf_q  <= rdata.flag;
				ps_q  <= rdata.status;
			end
			ST_GCD: begin
				if (x_q == '0 || y_q == '0) begin
					g_q   <= (x_q | y_q) << k_q;
					rn_q  <= '0;
					rd_q  <= '0;
					qn_q  <= dn_q;
					qd_q  <= dd_q;
					cnt_q <= '0;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 7'd1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q >= y_q) begin
					x_q <= (x_q - y_q) >> 1;
				end else begin
					y_q <= (y_q - x_q) >> 1;
				end
			end
			ST_DIV: begin
				if (tn >= {1'b0, g_q}) begin
					rn_q <= tn - {1'b0, g_q};
					qn_q <= {qn_q[62:0], 1'b1};
				end else begin
					rn_q <= tn;
					qn_q <= {qn_q[62:0], 1'b0};
				end
				if (td >= {1'b0, g_q}) begin
					rd_q <= td - {1'b0, g_q};
					qd_q <= {qd_q[62:0], 1'b1};
				end else begin
					rd_q <= td;
					qd_q <= {qd_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
			ST_DONE: ;
			default: ;
		endcase
		if (state_q == ST_DIV && cnt_q == 6'd63) begin
			pn_q <= neg_q ? -$signed({qn_q[62:0], tn >= {1'b0, g_q}})
			              :  $signed({qn_q[62:0], tn >= {1'b0, g_q}});
			pd_q <= {qd_q[61:0], td >= {1'b0, g_q}};
		end
		if (state_q == ST_DONE && out_free) begin
			res_num_q    <= pn_q;
			res_den_q    <= pd_q;
			res_flag_q   <= pf_q;
			res_status_q <= ps_q;
		end
	end

	// dividends are the original magnitudes, kept apart from the gcd working pair
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			dn_q <= nabs;
			dd_q <= 64'(df);
		end
	end

	assign empty    = !res_valid_q;
	assign res_num  = res_num_q;
	assign res_den  = res_den_q;
	assign cmp_flag = res_flag_q;
	assign status   = res_status_q;

	`RFA_NEVER(a_den_zero, res_valid_q && res_den_q == '0, "result denominator is zero")
	`RFA_CHECK(a_err_zero, res_valid_q && res_status_q |-> res_num_q == '0 && res_den_q == 63'd1, "bad error")
	`RFA_CHECK(a_gcd_live, (state_q == ST_GCD) |-> (x_q != '0 || y_q != '0), "gcd pair collapsed")

endmodule

// File: design/rational_fraction_alu.sv
// Rational arithmetic unit with gcd reduction.
// Input queue port: drive req_type and operands a_num/a_den, b_num/b_den
// and raise push; the item is taken on a clock edge with push high and
// full low. Result queue port: while empty is low, res_num/res_den,
// cmp_flag and status show the oldest result; pop takes it.
// A front stage runs the three operand multipliers and classifies the
// opcode; a two-entry queue then feeds the reduction engine, which runs a
// binary gcd (one subtract-and-shift step per cycle) followed by a
// restoring divide of numerator and denominator by the gcd. Items without
// reduction (compares, errors, zero results) skip the gcd and divide and
// go from idle straight to the done state. The engine pops a new item only
// in idle, so it finishes one fraction before taking another, and the gcd
// loop sets the rate.
// The front keeps accepting until the queue fills, so up to three items
// may be buffered while a result waits. If pop stays low, the finished
// result holds and the engine parks its next result until the slot frees.
// arst_n clears all queues and returns the engine to idle; no clear pass.
module rational_fraction_alu #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [3:0]         req_type,
	input  logic signed [31:0] a_num,
	input  logic [30:0]        a_den,
	input  logic signed [31:0] b_num,
	input  logic [30:0]        b_den,
	output logic               empty,
	input  logic               pop,
	output logic signed [63:0] res_num,
	output logic [62:0]        res_den,
	output logic               cmp_flag,
	output logic               status
);

	logic              q_push, q_full, q_valid, q_pop;
	rfa_pkg::q_entry_t q_wdata, q_rdata;

	rfa_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk, .arst_n, .push, .full, .req_type, .a_num, .a_den, .b_num, .b_den,
		.q_push, .q_full, .q_wdata
	);

	rfa_queue u_queue (
		.clk, .arst_n, .wr(q_push), .wdata(q_wdata), .q_full,
		.rd(q_pop), .q_valid, .rdata(q_rdata)
	);

	rfa_back u_back (
		.clk, .arst_n, .q_valid, .rdata(q_rdata), .q_pop, .pop, .empty,
		.res_num, .res_den, .cmp_flag, .status
	);

endmodule
